// ----- src/pipr_pkg.sv -----
// Shared types and constants for the point-in-polygon ray test.
// No dependencies; imported by pipr_edge and the top level.
package pipr_pkg;

  // Working coordinate width: covers ray end minus any coordinate
  localparam int DW = 16;
  localparam int PW = 2 * DW;
  localparam int XW = PW + 1;

  typedef logic signed [DW-1:0] coord_t;
  typedef logic signed [PW-1:0] prod_t;
  typedef logic signed [XW-1:0] cross_t;

  // x of the far end of the ray, beyond every coordinate
  localparam coord_t RAY_END_X = coord_t'(10000);
  localparam int MIN_VERTS = 3;

  typedef struct packed {
    logic en;
    logic last;
  } edge_ctl_t;

  typedef struct packed {
    logic valid;
    logic last;
    logic meet;
    logic coll;
    logic inbox;
  } edge_res_t;

endpackage

// ----- src/pipr_cell.sv -----
// One vertex cell of the rotating vertex ring.
// Takes a write from the host or the neighbor's vertex on a shift; no package.
module pipr_cell #(
  parameter int COORD_BITS = 14
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic                  shift_en,
  input  logic [COORD_BITS-1:0] wr_x,
  input  logic [COORD_BITS-1:0] wr_y,
  input  logic [COORD_BITS-1:0] nb_x,
  input  logic [COORD_BITS-1:0] nb_y,
  output logic [COORD_BITS-1:0] x,
  output logic [COORD_BITS-1:0] y
);

  logic [COORD_BITS-1:0] x_r, y_r;

  // Load on write, advance from the neighbor on shift, else hold
  always_ff @(posedge clk) begin
    if (wr_en) begin
      x_r <= wr_x;
      y_r <= wr_y;
    end else if (shift_en) begin
      x_r <= nb_x;
      y_r <= nb_y;
    end
  end

  assign x = x_r;
  assign y = y_r;

endmodule

// ----- src/pipr_edge.sv -----
// Two-stage edge evaluator: ray/edge intersection and collinear test.
// Depends on pipr_pkg for coordinate types and the ray end constant.
module pipr_edge (
  input  logic               clk,
  input  logic               rst_n,
  input  pipr_pkg::edge_ctl_t ctl,
  input  pipr_pkg::coord_t   ax,
  input  pipr_pkg::coord_t   ay,
  input  pipr_pkg::coord_t   bx,
  input  pipr_pkg::coord_t   by,
  input  pipr_pkg::coord_t   px,
  input  pipr_pkg::coord_t   py,
  output pipr_pkg::edge_res_t res
);
  import pipr_pkg::*;

  coord_t dyab, dxab, dxpb, dypb, dxrb;
  logic   a_eq, a_lt, b_eq, b_lt, pbox_nxt, side_nxt, t34_nxt;
  prod_t  p1_r, p2_r, p3_r;
  logic   pbox_r, side_r, t34_r;
  edge_ctl_t ctl_r;
  cross_t c1, c2;
  logic   z1, z2, meet;
  edge_res_t res_r;

  // Stage 1: differences, products and the flags that need no product
  always_comb begin
    dyab = by - ay;
    dxab = bx - ax;
    dxpb = px - bx;
    dypb = py - by;
    dxrb = RAY_END_X - bx;
    a_eq = (ay == py);
    a_lt = (ay < py);
    b_eq = (by == py);
    b_lt = (by < py);
    // ray side turns differ when the endpoints sit differently about py
    t34_nxt = (a_eq != b_eq) || (a_lt != b_lt);
    // an endpoint on the ray at or right of the point
    side_nxt = (a_eq && (ax >= px)) || (b_eq && (bx >= px));
    pbox_nxt = ((px >= ax) || (px >= bx)) && ((px <= ax) || (px <= bx)) &&
               ((py >= ay) || (py >= by)) && ((py <= ay) || (py <= by));
  end

  always_ff @(posedge clk) begin
    p1_r   <= prod_t'(dyab) * prod_t'(dxpb);
    p2_r   <= prod_t'(dxab) * prod_t'(dypb);
    p3_r   <= prod_t'(dyab) * prod_t'(dxrb);
    pbox_r <= pbox_nxt;
    side_r <= side_nxt;
    t34_r  <= t34_nxt;
  end

  // Stage 2: orientation of point and ray end against the edge
  always_comb begin
    c1   = cross_t'(p1_r) - cross_t'(p2_r);
    c2   = cross_t'(p3_r) - cross_t'(p2_r);
    z1   = (c1 == '0);
    z2   = (c2 == '0);
    // the ray end lies beyond every vertex, so it never sits in the edge box
    meet = (((z1 != z2) || (c1[XW-1] != c2[XW-1])) && t34_r) ||
           (z1 && pbox_r) || side_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r       <= '0;
      res_r.valid <= 1'b0;
      res_r.last  <= 1'b0;
    end else begin
      ctl_r       <= ctl;
      res_r.valid <= ctl_r.en;
      res_r.last  <= ctl_r.last;
    end
    res_r.meet  <= meet;
    res_r.coll  <= meet && z1;
    res_r.inbox <= pbox_r;
  end

  assign res = res_r;

endmodule

// ----- src/point_in_polygon_ray_test_core.sv -----
// Point-in-polygon core: vertex ring of pipr_cell, pipr_edge evaluator, control.
// Depends on pipr_pkg, pipr_cell and pipr_edge.
//
// Usage:
//   Input words are taken when start is high and busy is low. A word with
//   in_action 0 writes vertex in_vertex_index in that same cycle and keeps
//   busy low. A word with in_action 1 queries point (in_coord_x, in_coord_y)
//   and raises busy.
//   A query rotates the vertex ring once, one cell per clock, handing one
//   edge per cycle to the two-stage edge evaluator. After the sweep the core
//   waits for the evaluator's last result, then raises the answer strobe
//   out_valid for one cycle, with busy low again in that cycle. The
//   receiver cannot hold the result off. A new query is taken only once
//   busy is low again; vertex writes keep busy low.
//   The vertex count register is written over cfg_valid/cfg_ready; the
//   user must write it only while idle, which the block itself does not
//   enforce. cfg_ready is always high. Counts above MAX_VERTICES saturate.
//   Reset clears control state and the count; vertex cells keep no reset
//   value and must be written before a query uses them.
module point_in_polygon_ray_test_core #(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_BITS   = 14
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_action,
  input  logic [5:0]  in_vertex_index,
  input  logic [13:0] in_coord_x,
  input  logic [13:0] in_coord_y,
  output logic        out_valid,
  output logic        out_inside_res,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_vertex_count
);
  import pipr_pkg::*;

  localparam int SW   = $clog2(MAX_VERTICES);
  localparam int NW   = $clog2(MAX_VERTICES + 1);
  localparam int CMPW = (NW > 7) ? NW : 7;
  localparam logic [SW-1:0] LAST_STEP = SW'(MAX_VERTICES - 1);

  typedef enum logic [1:0] {S_IDLE, S_SWEEP, S_WAIT} state_t;

  state_t state_r;
  logic [6:0]    cfg_r;
  logic [SW-1:0] step_r;
  logic [NW-1:0] n_r, n_sat;
  logic          n_ok_r;
  logic [COORD_BITS-1:0] px_r, py_r, v0x_r, v0y_r;
  logic          par_r, dec_r, dres_r;
  logic          out_valid_r, out_res_r;

  logic [COORD_BITS-1:0] cx [MAX_VERTICES];
  logic [COORD_BITS-1:0] cy [MAX_VERTICES];

  logic      accept, query, shift_en, wrap;
  logic      par_nxt, dec_nxt, dres_nxt;
  edge_ctl_t ctl;
  edge_res_t eres;
  coord_t    ax, ay, bx, by, px, py;

  assign accept    = start && !busy;
  assign query     = accept && in_action;
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign shift_en  = (state_r == S_SWEEP);

  // Saturate the vertex count to the ring size
  assign n_sat = (CMPW'(cfg_r) > CMPW'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : NW'(cfg_r);

  // Vertex ring: each cell takes its right neighbor on a shift
  for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
    logic wr_en;
    assign wr_en = accept && !in_action && (32'(in_vertex_index) == 32'(k));
    pipr_cell #(.COORD_BITS(COORD_BITS)) u_cell (
      .clk      (clk),
      .wr_en    (wr_en),
      .shift_en (shift_en),
      .wr_x     (in_coord_x[COORD_BITS-1:0]),
      .wr_y     (in_coord_y[COORD_BITS-1:0]),
      .nb_x     (cx[(k + 1) % MAX_VERTICES]),
      .nb_y     (cy[(k + 1) % MAX_VERTICES]),
      .x        (cx[k]),
      .y        (cy[k])
    );
  end

  // Present edge (v[i], v[i+1]); the closing edge uses the saved first vertex
  assign wrap = (NW'(step_r) == NW'(n_r - 1'b1));
  assign ax = coord_t'($signed(cx[0]));
  assign ay = coord_t'($signed(cy[0]));
  assign bx = wrap ? coord_t'($signed(v0x_r)) : coord_t'($signed(cx[1]));
  assign by = wrap ? coord_t'($signed(v0y_r)) : coord_t'($signed(cy[1]));
  assign px = coord_t'($signed(px_r));
  assign py = coord_t'($signed(py_r));
  assign ctl.en   = shift_en && (NW'(step_r) < n_r);
  assign ctl.last = shift_en && (step_r == LAST_STEP);

  pipr_edge u_edge (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .ax    (ax),
    .ay    (ay),
    .bx    (bx),
    .by    (by),
    .px    (px),
    .py    (py),
    .res   (eres)
  );

  // Fold in one edge: first collinear hit decides, else count crossings
  always_comb begin
    par_nxt  = par_r;
    dec_nxt  = dec_r;
    dres_nxt = dres_r;
    if (eres.valid && !dec_r && eres.meet) begin
      if (eres.coll) begin
        dec_nxt  = 1'b1;
        dres_nxt = eres.inbox;
      end else begin
        par_nxt = !par_r;
      end
    end
  end

  // Control state and registered result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cfg_r       <= '0;
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        cfg_r <= cfg_vertex_count;
      end
      unique case (state_r)
        S_IDLE: begin
          if (query) begin
            state_r <= S_SWEEP;
            step_r  <= '0;
          end
        end
        S_SWEEP: begin
          step_r <= step_r + 1'b1;
          if (step_r == LAST_STEP) begin
            state_r <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (eres.valid || eres.last) begin
            if (eres.last) begin
              state_r     <= S_IDLE;
              out_valid_r <= 1'b1;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Query payload and running answer
  always_ff @(posedge clk) begin
    if (query) begin
      px_r   <= in_coord_x[COORD_BITS-1:0];
      py_r   <= in_coord_y[COORD_BITS-1:0];
      v0x_r  <= cx[0];
      v0y_r  <= cy[0];
      n_r    <= n_sat;
      n_ok_r <= (n_sat >= NW'(MIN_VERTS));
      par_r  <= 1'b0;
      dec_r  <= 1'b0;
      dres_r <= 1'b0;
    end else begin
      par_r  <= par_nxt;
      dec_r  <= dec_nxt;
      dres_r <= dres_nxt;
    end
    if (eres.last) begin
      out_res_r <= n_ok_r && (dec_nxt ? dres_nxt : par_nxt);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_inside_res = out_res_r;

endmodule

// ----- src/pipr_chk.sv -----
// Port-level checks for the point-in-polygon core, bound to the top level.
// Depends on point_in_polygon_ray_test_core port names only.
module pipr_chk (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_action,
  input logic out_valid
);

  // A query holds the core busy from the next cycle
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_action |=> busy)
    else $error("query accepted without raising busy");

  // The answer comes with busy already low
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // Busy only ends with an answer
  a_fell_out: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result");

  // Strobes never come back to back
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // Reset drops busy and the strobe
  a_reset: assert property (@(posedge clk)
    !rst_n |=> (!busy && !out_valid))
    else $error("control not cleared by reset");

endmodule

bind point_in_polygon_ray_test_core pipr_chk u_pipr_chk (.*);
